// ===== rtl/triangle_face_normal_defines.svh =====
// ----------------------------------------------------------------------------
// Triangle face normal assertion macros
// Shared concurrent assertion forms for the face normal block.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_FACE_NORMAL_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_DEFINES_SVH

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define TFN_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("face normal check failed");

// The expression holds at every clock edge outside reset.
`define TFN_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("face normal check failed");

`endif

// ===== rtl/tfn_pkg.sv =====
// ----------------------------------------------------------------------------
// Triangle face normal package
// Request and result types, and the records passed along the cell chains.
// ----------------------------------------------------------------------------
package tfn_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int NORM_WIDTH  = 16;
    // Scaled cross product magnitudes carry their top bit at position 30.
    localparam int MAG_WIDTH   = 31;
    localparam int SUM_WIDTH   = 64;
    localparam int ROOT_WIDTH  = 32;
    localparam int REM_WIDTH   = 34;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] a_x;
        logic signed [COORD_WIDTH-1:0] a_y;
        logic signed [COORD_WIDTH-1:0] a_z;
        logic signed [COORD_WIDTH-1:0] b_x;
        logic signed [COORD_WIDTH-1:0] b_y;
        logic signed [COORD_WIDTH-1:0] b_z;
        logic signed [COORD_WIDTH-1:0] c_x;
        logic signed [COORD_WIDTH-1:0] c_y;
        logic signed [COORD_WIDTH-1:0] c_z;
    } t_tri_in;

    typedef struct packed {
        logic signed [NORM_WIDTH-1:0] norm_x;
        logic signed [NORM_WIDTH-1:0] norm_y;
        logic signed [NORM_WIDTH-1:0] norm_z;
        logic                         degenerate;
    } t_tri_out;

    typedef struct packed {
        logic [2:0] neg;
        logic       deg;
    } t_flags;

    typedef struct packed {
        logic [2:0][MAG_WIDTH-1:0] m;
        t_flags                    flags;
    } t_side;

    typedef struct packed {
        logic [REM_WIDTH-1:0]  rem;
        logic [ROOT_WIDTH-1:0] root;
        logic [SUM_WIDTH-1:0]  s;
    } t_sqrt;

endpackage

// ===== rtl/triangle_face_normal.sv =====
// ----------------------------------------------------------------------------
// Triangle face normal
// Unit face normal of a triangle, fully pipelined through chains of cells.
// ----------------------------------------------------------------------------
// One triangle is taken in every cycle and o_busy never rises. Each result
// appears on o_result, marked by o_done, after passing through seven front
// stages for edges, cross product, normalization and squared length, one
// square root cell per root bit (32), one division cell per quotient bit
// (NORMAL_FRAC_BITS + 1) and an output register. Results cannot be held off;
// the receiver must take o_result in the cycle that o_done is high.
`include "triangle_face_normal_defines.svh"

module triangle_face_normal #(
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  tfn_pkg::t_tri_in  i_tri,
    output logic              o_busy,
    output logic              o_done,
    output tfn_pkg::t_tri_out o_result
);
    import tfn_pkg::*;

    localparam int EW  = COORD_WIDTH + 1;
    localparam int PW  = 2 * EW;
    localparam int NW  = PW + 1;
    localparam int PBW = $clog2(NW + 1);
    localparam int QB  = NORMAL_FRAC_BITS + 1;
    localparam int DW  = ROOT_WIDTH + NORMAL_FRAC_BITS + 1;
    localparam int SQW = 2 * MAG_WIDTH;
    localparam int LAT = 8 + ROOT_WIDTH + QB;
    localparam int QXW = QB + NORM_WIDTH;

    // Stage 1: edges.
    logic                        r_v1;
    logic signed [2:0][EW-1:0]   r_e1, r_e2;
    // Stage 2: products.
    logic                        r_v2;
    logic signed [5:0][PW-1:0]   r_pr;
    // Stage 3: cross product.
    logic                        r_v3;
    logic [2:0][NW-1:0]          r_n;
    // Stage 4: magnitudes and shift amount.
    logic                        r_v4;
    logic [2:0][NW-1:0]          r_mag;
    logic [PBW-1:0]              r_sh;
    t_flags                      r_fl4;
    // Stage 5: normalized magnitudes.
    logic                        r_v5;
    logic [2:0][MAG_WIDTH-1:0]   r_m5;
    t_flags                      r_fl5;
    // Stage 6: squares.
    logic                        r_v6;
    logic [2:0][SQW-1:0]         r_sq;
    t_side                       r_sd6;
    // Stage 7: squared length.
    logic                        r_v7;
    logic [SUM_WIDTH-1:0]        r_sum;
    t_side                       r_sd7;

    logic                        r_done;
    t_tri_out                    r_res;

    logic [2:0][NW-1:0]          n_mag;
    logic [2:0]                  n_neg;
    logic [NW-1:0]               n_any;
    logic [PBW-1:0]              n_sh;
    logic [2:0][MAG_WIDTH-1:0]   n_m;
    logic [NW+MAG_WIDTH-1:0]     w_wide [3];
    t_tri_out                    n_res;
    logic [QXW-1:0]              w_qx;
    logic [NORM_WIDTH-1:0]       w_qs;

    logic                        w_sv   [ROOT_WIDTH+1];
    t_sqrt                       w_sqd  [ROOT_WIDTH+1];
    t_side                       w_sd   [ROOT_WIDTH+1];
    logic                        w_dv   [QB+1];
    logic [2:0][DW-1:0]          w_rem  [QB+1];
    logic [2:0][QB-1:0]          w_q    [QB+1];
    logic [ROOT_WIDTH-1:0]       w_len  [QB+1];
    t_flags                      w_fl   [QB+1];

    assign o_busy = 1'b0;

    always_comb begin
        n_any = '0;
        for (int k = 0; k < 3; k++) begin
            n_neg[k] = r_n[k][NW-1];
            n_mag[k] = n_neg[k] ? (~r_n[k] + NW'(1)) : r_n[k];
            n_any    = n_any | n_mag[k];
        end
        // Shift amount is one more than the top set bit position.
        n_sh = '0;
        for (int i = 0; i < NW; i++) begin
            if (n_any[i]) begin
                n_sh = PBW'(i + 1);
            end
        end
    end

    // Placing the magnitude above MAG_WIDTH zeros and shifting right by
    // top bit plus one puts the top bit at position 30 in every case.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_wide[k] = {r_mag[k], {MAG_WIDTH{1'b0}}} >> r_sh;
            n_m[k]    = w_wide[k][MAG_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_v5   <= 1'b0;
            r_v6   <= 1'b0;
            r_v7   <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_v4   <= r_v3;
            r_v5   <= r_v4;
            r_v6   <= r_v5;
            r_v7   <= r_v6;
        end
        r_e1[0] <= $signed({i_tri.b_x[COORD_WIDTH-1], i_tri.b_x})
                 - $signed({i_tri.a_x[COORD_WIDTH-1], i_tri.a_x});
        r_e1[1] <= $signed({i_tri.b_y[COORD_WIDTH-1], i_tri.b_y})
                 - $signed({i_tri.a_y[COORD_WIDTH-1], i_tri.a_y});
        r_e1[2] <= $signed({i_tri.b_z[COORD_WIDTH-1], i_tri.b_z})
                 - $signed({i_tri.a_z[COORD_WIDTH-1], i_tri.a_z});
        r_e2[0] <= $signed({i_tri.c_x[COORD_WIDTH-1], i_tri.c_x})
                 - $signed({i_tri.a_x[COORD_WIDTH-1], i_tri.a_x});
        r_e2[1] <= $signed({i_tri.c_y[COORD_WIDTH-1], i_tri.c_y})
                 - $signed({i_tri.a_y[COORD_WIDTH-1], i_tri.a_y});
        r_e2[2] <= $signed({i_tri.c_z[COORD_WIDTH-1], i_tri.c_z})
                 - $signed({i_tri.a_z[COORD_WIDTH-1], i_tri.a_z});

        r_pr[0] <= $signed(r_e1[1]) * $signed(r_e2[2]);
        r_pr[1] <= $signed(r_e1[2]) * $signed(r_e2[1]);
        r_pr[2] <= $signed(r_e1[2]) * $signed(r_e2[0]);
        r_pr[3] <= $signed(r_e1[0]) * $signed(r_e2[2]);
        r_pr[4] <= $signed(r_e1[0]) * $signed(r_e2[1]);
        r_pr[5] <= $signed(r_e1[1]) * $signed(r_e2[0]);

        r_n[0] <= {r_pr[0][PW-1], r_pr[0]} - {r_pr[1][PW-1], r_pr[1]};
        r_n[1] <= {r_pr[2][PW-1], r_pr[2]} - {r_pr[3][PW-1], r_pr[3]};
        r_n[2] <= {r_pr[4][PW-1], r_pr[4]} - {r_pr[5][PW-1], r_pr[5]};

        r_mag     <= n_mag;
        r_sh      <= n_sh;
        r_fl4.neg <= n_neg;
        r_fl4.deg <= (n_any == '0);

        r_m5  <= n_m;
        r_fl5 <= r_fl4;

        for (int k = 0; k < 3; k++) begin
            r_sq[k] <= SQW'(r_m5[k]) * SQW'(r_m5[k]);
        end
        r_sd6.m     <= r_m5;
        r_sd6.flags <= r_fl5;

        r_sum <= SUM_WIDTH'(r_sq[0]) + SUM_WIDTH'(r_sq[1]) + SUM_WIDTH'(r_sq[2]);
        r_sd7 <= r_sd6;
    end

    assign w_sv[0]       = r_v7;
    assign w_sqd[0].rem  = '0;
    assign w_sqd[0].root = '0;
    assign w_sqd[0].s    = r_sum;
    assign w_sd[0]       = r_sd7;

    for (genvar g = 0; g < ROOT_WIDTH; g++) begin : g_sqrt
        tfn_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_sv[g]),
            .i_sq    (w_sqd[g]),
            .i_side  (w_sd[g]),
            .o_valid (w_sv[g+1]),
            .o_sq    (w_sqd[g+1]),
            .o_side  (w_sd[g+1])
        );
    end

    // Dividend is the magnitude scaled by the fraction bits plus half the
    // length, so the truncating quotient rounds half up.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_rem[0][k] = (DW'(w_sd[ROOT_WIDTH].m[k]) << NORMAL_FRAC_BITS)
                        + DW'(w_sqd[ROOT_WIDTH].root >> 1);
        end
    end
    assign w_dv[0]  = w_sv[ROOT_WIDTH];
    assign w_q[0]   = '0;
    assign w_len[0] = w_sqd[ROOT_WIDTH].root;
    assign w_fl[0]  = w_sd[ROOT_WIDTH].flags;

    for (genvar g = 0; g < QB; g++) begin : g_div
        tfn_div_cell #(
            .DW    (DW),
            .QB    (QB),
            .SHIFT (QB - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_dv[g]),
            .i_rem   (w_rem[g]),
            .i_q     (w_q[g]),
            .i_len   (w_len[g]),
            .i_flags (w_fl[g]),
            .o_valid (w_dv[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_q     (w_q[g+1]),
            .o_len   (w_len[g+1]),
            .o_flags (w_fl[g+1])
        );
    end

    always_comb begin
        n_res.degenerate = w_fl[QB].deg;
        n_res.norm_x = '0;
        n_res.norm_y = '0;
        n_res.norm_z = '0;
        w_qx = '0;
        w_qs = '0;
        for (int k = 0; k < 3; k++) begin
            w_qx = QXW'(w_q[QB][k]);
            w_qs = (w_qx > QXW'(32767)) ? NORM_WIDTH'(32767) : w_qx[NORM_WIDTH-1:0];
            if (w_fl[QB].neg[k]) begin
                w_qs = ~w_qs + NORM_WIDTH'(1);
            end
            if (w_fl[QB].deg) begin
                w_qs = '0;
            end
            case (k)
                0:       n_res.norm_x = w_qs;
                1:       n_res.norm_y = w_qs;
                default: n_res.norm_z = w_qs;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_dv[QB];
        end
        r_res <= n_res;
    end

    assign o_done   = r_done;
    assign o_result = r_res;

    `TFN_ASSERT_IMPLY(a_done_follows_request, i_clk, i_rst_n, o_done, $past(i_start, LAT))
    `TFN_ASSERT_IMPLY(a_degenerate_zero, i_clk, i_rst_n, o_done && o_result.degenerate, o_result.norm_x == '0 && o_result.norm_y == '0 && o_result.norm_z == '0)
    `TFN_ASSERT_ALWAYS(a_never_busy, i_clk, i_rst_n, !o_busy)

endmodule

// ===== rtl/tfn_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// Square root cell
// Resolves one root bit per cycle from the next two bits of the radicand.
// ----------------------------------------------------------------------------
module tfn_sqrt_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  tfn_pkg::t_sqrt i_sq,
    input  tfn_pkg::t_side i_side,
    output logic          o_valid,
    output tfn_pkg::t_sqrt o_sq,
    output tfn_pkg::t_side o_side
);
    import tfn_pkg::*;

    logic                 r_valid;
    t_sqrt                r_sq;
    t_side                r_side;
    t_sqrt                n_sq;
    logic [REM_WIDTH:0]   remx;
    logic [REM_WIDTH:0]   trial;

    always_comb begin
        remx  = {i_sq.rem[REM_WIDTH-2:0], i_sq.s[SUM_WIDTH-1:SUM_WIDTH-2]};
        trial = {1'b0, i_sq.root, 2'b01};
        n_sq.s = {i_sq.s[SUM_WIDTH-3:0], 2'b00};
        if (remx >= trial) begin
            n_sq.rem  = REM_WIDTH'(remx - trial);
            n_sq.root = {i_sq.root[ROOT_WIDTH-2:0], 1'b1};
        end else begin
            n_sq.rem  = remx[REM_WIDTH-1:0];
            n_sq.root = {i_sq.root[ROOT_WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_sq   <= n_sq;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_sq    = r_sq;
    assign o_side  = r_side;

endmodule

// ===== rtl/tfn_div_cell.sv =====
// ----------------------------------------------------------------------------
// Division cell
// Resolves one quotient bit for each of the three normal components.
// ----------------------------------------------------------------------------
module tfn_div_cell #(
    parameter int DW    = 47,
    parameter int QB    = 15,
    parameter int SHIFT = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [2:0][DW-1:0]        i_rem,
    input  logic [2:0][QB-1:0]        i_q,
    input  logic [tfn_pkg::ROOT_WIDTH-1:0] i_len,
    input  tfn_pkg::t_flags           i_flags,
    output logic                      o_valid,
    output logic [2:0][DW-1:0]        o_rem,
    output logic [2:0][QB-1:0]        o_q,
    output logic [tfn_pkg::ROOT_WIDTH-1:0] o_len,
    output tfn_pkg::t_flags           o_flags
);
    import tfn_pkg::*;

    logic                  r_valid;
    logic [2:0][DW-1:0]    r_rem;
    logic [2:0][QB-1:0]    r_q;
    logic [ROOT_WIDTH-1:0] r_len;
    t_flags                r_flags;
    logic [2:0][DW-1:0]    n_rem;
    logic [2:0][QB-1:0]    n_q;
    logic [DW-1:0]         dvs;

    always_comb begin
        dvs = DW'(i_len) << SHIFT;
        for (int k = 0; k < 3; k++) begin
            if (i_rem[k] >= dvs) begin
                n_rem[k] = i_rem[k] - dvs;
                n_q[k]   = {i_q[k][QB-2:0], 1'b1};
            end else begin
                n_rem[k] = i_rem[k];
                n_q[k]   = {i_q[k][QB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_rem   <= n_rem;
        r_q     <= n_q;
        r_len   <= i_len;
        r_flags <= i_flags;
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_q     = r_q;
    assign o_len   = r_len;
    assign o_flags = r_flags;

endmodule

// ===== tb/triangle_face_normal_test.sv =====
// ----------------------------------------------------------------------------
// Triangle face normal testbench
// Streams triangles into the face normal block and checks every unit normal
// against a bit-exact predictor built from wide integer arithmetic.
// ----------------------------------------------------------------------------
module triangle_face_normal_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tfn_pkg::*;

    localparam int FRAC_BITS   = 14;
    localparam int LATENCY     = 41 + FRAC_BITS;
    localparam int CYCLE_LIMIT = 200000;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_start = 1'b0;
    t_tri_in  i_tri = '0;
    logic     o_busy;
    logic     o_done;
    t_tri_out o_result;

    triangle_face_normal #(.NORMAL_FRAC_BITS(FRAC_BITS)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_tri    (i_tri),
        .o_busy   (o_busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_tri_in  pending_tris[$];
    t_tri_out expected_normals[$];
    int       idle_pct = 14;
    int       errors = 0;
    int       sent = 0;
    int       degenerate_seen = 0;
    int       cycle_count = 0;

    function automatic logic [127:0] mag128(logic signed [127:0] v);
        return v[127] ? -v : v;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] r;
        logic [63:0] bitv;
        r = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= r + bitv) begin
                n = n - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    function automatic t_tri_out face_normal(t_tri_in t);
        logic signed [127:0] e1[3];
        logic signed [127:0] e2[3];
        logic signed [127:0] n[3];
        logic [127:0] mag[3];
        logic [127:0] any_bits;
        logic [63:0]  m[3];
        logic [63:0]  sum;
        logic [63:0]  len;
        logic [63:0]  q;
        logic [15:0]  comp[3];
        int           top;
        t_tri_out     r;
        e1[0] = 128'(t.b_x) - 128'(t.a_x);
        e1[1] = 128'(t.b_y) - 128'(t.a_y);
        e1[2] = 128'(t.b_z) - 128'(t.a_z);
        e2[0] = 128'(t.c_x) - 128'(t.a_x);
        e2[1] = 128'(t.c_y) - 128'(t.a_y);
        e2[2] = 128'(t.c_z) - 128'(t.a_z);
        n[0] = e1[1] * e2[2] - e1[2] * e2[1];
        n[1] = e1[2] * e2[0] - e1[0] * e2[2];
        n[2] = e1[0] * e2[1] - e1[1] * e2[0];
        any_bits = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = mag128(n[i]);
            any_bits = any_bits | mag[i];
        end
        r = '0;
        if (any_bits == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        top = 0;
        for (int b = 0; b < 128; b++) if (any_bits[b]) top = b;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            if (top <= 30) m[i] = 64'(mag[i] << (30 - top));
            else m[i] = 64'(mag[i] >> (top - 30));
            sum = sum + m[i] * m[i];
        end
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << FRAC_BITS) + (len >> 1)) / len;
            if (q > 32767) q = 32767;
            comp[i] = n[i][127] ? 16'(-q) : 16'(q);
        end
        r.norm_x = comp[0];
        r.norm_y = comp[1];
        r.norm_z = comp[2];
        return r;
    endfunction

    // Request driver: holds start high across back-to-back requests.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) sent <= sent + 1;
            if ((!i_start || !o_busy) && pending_tris.size() > 0
                    && $urandom_range(99) >= idle_pct) begin
                i_start <= 1'b1;
                i_tri   <= pending_tris.pop_front();
            end else if (!i_start || !o_busy) begin
                i_start <= 1'b0;
            end
        end
    end

    // Prediction is made when a request is accepted.
    always @(posedge i_clk) begin
        if (i_rst_n && i_start && !o_busy)
            expected_normals.push_back(face_normal(i_tri));
    end

    always @(posedge i_clk) begin
        t_tri_out exp_r;
        if (i_rst_n && o_done) begin
            if (expected_normals.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, o_result);
                errors++;
            end else begin
                exp_r = expected_normals.pop_front();
                if (exp_r.degenerate) degenerate_seen++;
                if (o_result.norm_x !== exp_r.norm_x || o_result.norm_y !== exp_r.norm_y
                        || o_result.norm_z !== exp_r.norm_z
                        || o_result.degenerate !== exp_r.degenerate) begin
                    $display("%0t: mismatch expected %0d %0d %0d deg %b, actual %0d %0d %0d deg %b",
                        $realtime, exp_r.norm_x, exp_r.norm_y, exp_r.norm_z, exp_r.degenerate,
                        o_result.norm_x, o_result.norm_y, o_result.norm_z,
                        o_result.degenerate);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout", $realtime);
            $display("triangle_face_normal_test failed");
            $finish;
        end
    end

    function automatic logic [15:0] rand_coord(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(65535) >> $urandom_range(15));
            default: return 16'($signed(16'($urandom_range(64))) - 16'sd32);
        endcase
    endfunction

    task automatic add_tri(logic [15:0] v[9]);
        t_tri_in t;
        t = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]};
        pending_tris.push_back(t);
    endtask

    task automatic add_random(int count);
        logic [15:0] v[9];
        int mode;
        for (int k = 0; k < count; k++) begin
            mode = $urandom_range(2);
            foreach (v[j]) v[j] = rand_coord(mode);
            // Some triangles are made collinear or have repeated vertices.
            case ($urandom_range(9))
                0: for (int j = 0; j < 3; j++) v[3 + j] = v[j];
                1: for (int j = 0; j < 3; j++) v[6 + j] = v[3 + j];
                2: for (int j = 0; j < 3; j++) v[6 + j] = 16'(2 * v[3 + j] - v[j]);
                default: ;
            endcase
            add_tri(v);
        end
    endtask

    task automatic drain();
        while (pending_tris.size() > 0 || expected_normals.size() > 0 || i_start)
            @(posedge i_clk);
    endtask

    initial begin
        logic [15:0] v[9];
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: degenerate, axis-aligned faces, extremes, and rounding.
        v = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                       add_tri(v);
        v = '{0, 0, 0, 256, 0, 0, 0, 256, 0};                   add_tri(v);
        v = '{0, 0, 0, 0, 256, 0, 0, 0, 256};                   add_tri(v);
        v = '{0, 0, 0, 0, 0, 256, 256, 0, 0};                   add_tri(v);
        v = '{0, 0, 0, 0, 256, 0, 256, 0, 0};                   add_tri(v);
        v = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
              16'h8000, 16'h7fff, 16'h8000};                    add_tri(v);
        v = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff,
              16'h7fff, 16'h7fff, 16'h8000};                    add_tri(v);
        v = '{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
              16'h8000, 16'h8000, 16'h7fff};                    add_tri(v);
        v = '{0, 0, 0, 1, 0, 0, 0, 1, 0};                       add_tri(v);
        v = '{0, 0, 0, 1, 1, 0, 0, 1, 1};                       add_tri(v);
        v = '{0, 0, 0, 1, 2, 3, 2, 4, 6};                       add_tri(v);
        v = '{5, 5, 5, 5, 5, 5, 9, 1, 3};                       add_tri(v);
        v = '{16'hffff, 16'hffff, 16'hffff, 0, 0, 0, 1, 1, 0};  add_tri(v);
        v = '{0, 0, 0, 3, 0, 0, 0, 4, 12};                      add_tri(v);
        v = '{0, 0, 0, 16'hffff, 16'hffff, 0, 1, 16'hffff, 16'hffff}; add_tri(v);
        add_random(250);
        drain();
        idle_pct = 49;
        add_random(250);
        drain();
        idle_pct = 0;
        add_random(250);
        drain();
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("Sent %0d triangles in three idle phases, %0d degenerate results.",
                 sent, degenerate_seen);
        if (errors == 0 && expected_normals.size() == 0) begin
            $display("triangle_face_normal_test passed");
        end else begin
            $display("triangle_face_normal_test failed");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/tfn_pkg.sv
rtl/tfn_sqrt_cell.sv
rtl/tfn_div_cell.sv
rtl/triangle_face_normal.sv
tb/triangle_face_normal_test.sv
